@@ rtl/core/lcs_pkg.sv @@
package lcs_pkg;

    localparam int NUM_LEDS = 16;
    localparam int LED_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int ROW_W    = 24;

    // Command codes
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Byte position inside one LED row, in transmit order
    localparam logic [1:0] SUB_GREEN = 2'd0;
    localparam logic [1:0] SUB_RED   = 2'd1;
    localparam logic [1:0] SUB_BLUE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_BIT_PERIOD = 2'd1;
    localparam logic [1:0] REG_ZERO_HIGH  = 2'd2;
    localparam logic [1:0] REG_ONE_HIGH   = 2'd3;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [3:0] pixel;
        logic [1:0] cmd;
    } item_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic [7:0] bit_period;
        logic [7:0] zero_high;
        logic [7:0] one_high;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [LED_W-1:0] row;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } set_req_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } res_t;

    // Row layout: green in the low byte, then red, then blue
    function automatic logic [7:0] row_byte(input logic [ROW_W-1:0] row,
                                            input logic [1:0] sub);
        logic [7:0] b;
        case (sub)
            SUB_GREEN: b = row[7:0];
            SUB_RED:   b = row[15:8];
            SUB_BLUE:  b = row[23:16];
            default:   b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] k);
        logic [15:0] p;
        p = 16'(c) * 16'(k);
        return p[15:8];
    endfunction

endpackage

@@ rtl/core/lcs_ram.sv @@
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/lcs_store.sv @@
module lcs_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lcs_pkg::set_req_t         set_req,
    input  logic [7:0]                brightness,
    input  logic [lcs_pkg::LED_W-1:0] rd_row,
    output logic [lcs_pkg::ROW_W-1:0] cur_row
);
    import lcs_pkg::*;

    // Write stage: scaled colours are registered here before they land in the RAM
    logic             wr_valid_reg;
    logic [LED_W-1:0] wr_row_reg;
    logic [ROW_W-1:0] wr_data_reg;

    logic [NUM_LEDS-1:0] row_valid_reg;

    // Read side bookkeeping, aligned with the registered RAM output
    logic             fwd_hit_reg;
    logic [ROW_W-1:0] fwd_data_reg;
    logic             rvalid_reg;
    logic [LED_W-1:0] raddr_q_reg;

    logic [ROW_W-1:0] ram_q;
    logic [ROW_W-1:0] row_data;
    logic             fwd_hit;

    lcs_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NUM_LEDS)
    ) u_ram (
        .clk  (clk),
        .we   (wr_valid_reg),
        .waddr(wr_row_reg),
        .wdata(wr_data_reg),
        .raddr(rd_row),
        .rdata(ram_q)
    );

    assign fwd_hit = wr_valid_reg && (wr_row_reg == rd_row);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
            rvalid_reg    <= 1'b0;
            raddr_q_reg   <= '0;
        end
        else
        begin
            wr_valid_reg <= set_req.valid;
            if (wr_valid_reg)
            begin
                row_valid_reg[wr_row_reg] <= 1'b1;
            end
            fwd_hit_reg <= fwd_hit;
            rvalid_reg  <= row_valid_reg[rd_row] || fwd_hit;
            raddr_q_reg <= rd_row;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_row_reg   <= set_req.row;
        wr_data_reg  <= {scale(set_req.blue, brightness),
                         scale(set_req.red, brightness),
                         scale(set_req.green, brightness)};
        fwd_data_reg <= wr_data_reg;
    end

    // Never-written rows read as zero; the write in flight wins over the RAM
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            row_data = fwd_data_reg;
        end
        else if (rvalid_reg)
        begin
            row_data = ram_q;
        end
        else
        begin
            row_data = '0;
        end
    end

    assign cur_row = (wr_valid_reg && (wr_row_reg == raddr_q_reg)) ? wr_data_reg : row_data;

endmodule

@@ rtl/core/lcs_wave.sv @@
module lcs_wave (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  lcs_pkg::item_t            item,
    input  lcs_pkg::cfg_t             cfg,
    input  logic [lcs_pkg::ROW_W-1:0] cur_row,
    output lcs_pkg::res_t             res,
    output lcs_pkg::set_req_t         set_req,
    output logic [lcs_pkg::LED_W-1:0] rd_row,
    output logic                      sending
);
    import lcs_pkg::*;

    logic             sending_reg, sending_next;
    logic [LED_W-1:0] row_reg, row_next;
    logic [1:0]       sub_reg, sub_next;
    logic [2:0]       bit_reg, bit_next;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       shift_reg, shift_next;

    logic             start;
    logic             run;
    logic [LED_W-1:0] row_inc;
    logic [LED_W-1:0] e_row;
    logic [1:0]       e_sub;
    logic [2:0]       e_bit;
    logic [7:0]       e_tick;
    logic [7:0]       e_shift;
    logic [7:0]       high;
    logic             bit_end;
    logic             last_byte;
    logic [1:0]       n_sub;
    logic [LED_W-1:0] n_row;

    // Wrap to row 0 after the last LED so the prefetch is ready for the next frame
    assign row_inc = (row_reg == LED_W'(NUM_LEDS - 1)) ? '0 : row_reg + LED_W'(1);
    // Prefetch the row that holds the next byte to send
    assign rd_row  = (sub_reg == SUB_BLUE) ? row_inc : row_reg;

    assign start = step && !sending_reg && (item.cmd == CMD_START);
    assign run   = step && (sending_reg || start);

    assign e_row   = start ? '0 : row_reg;
    assign e_sub   = start ? SUB_GREEN : sub_reg;
    assign e_bit   = start ? '0 : bit_reg;
    assign e_tick  = start ? '0 : tick_reg;
    assign e_shift = start ? row_byte(cur_row, SUB_GREEN) : shift_reg;

    assign high      = e_shift[7] ? cfg.one_high : cfg.zero_high;
    assign bit_end   = ({1'b0, e_tick} + 9'd1) >= {1'b0, cfg.bit_period};
    assign last_byte = (e_row == LED_W'(NUM_LEDS - 1)) && (e_sub == SUB_BLUE);
    assign n_sub     = (e_sub == SUB_BLUE) ? SUB_GREEN : e_sub + 2'd1;
    assign n_row     = (e_sub == SUB_BLUE) ? row_inc : e_row;

    always_comb
    begin
        sending_next = sending_reg;
        row_next     = row_reg;
        sub_next     = sub_reg;
        bit_next     = bit_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        res          = '0;
        if (run)
        begin
            res.busy_res   = 1'b1;
            res.line_level = e_tick < high;
            res.rejected   = sending_reg && ((item.cmd == CMD_SET) || (item.cmd == CMD_START));
            sending_next   = 1'b1;
            row_next       = e_row;
            sub_next       = e_sub;
            bit_next       = e_bit;
            shift_next     = e_shift;
            if (bit_end)
            begin
                tick_next  = '0;
                shift_next = {e_shift[6:0], 1'b0};
                bit_next   = e_bit + 3'd1;
                if (e_bit == 3'd7)
                begin
                    if (last_byte)
                    begin
                        res.frame_done = 1'b1;
                        sending_next   = 1'b0;
                        row_next       = '0;
                        sub_next       = SUB_GREEN;
                        shift_next     = '0;
                    end
                    else
                    begin
                        row_next   = n_row;
                        sub_next   = n_sub;
                        shift_next = row_byte(cur_row, n_sub);
                    end
                end
            end
            else
            begin
                tick_next = e_tick + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            row_reg     <= '0;
            sub_reg     <= SUB_GREEN;
            bit_reg     <= '0;
            tick_reg    <= '0;
            shift_reg   <= '0;
        end
        else
        begin
            sending_reg <= sending_next;
            row_reg     <= row_next;
            sub_reg     <= sub_next;
            bit_reg     <= bit_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
        end
    end

    // Drop set-pixel commands for LEDs past the end of the chain
    assign set_req.valid = step && !sending_reg && (item.cmd == CMD_SET)
                           && (int'(item.pixel) < NUM_LEDS);
    assign set_req.row   = LED_W'(item.pixel);
    assign set_req.red   = item.red;
    assign set_req.green = item.green;
    assign set_req.blue  = item.blue;

    assign sending = sending_reg;

endmodule

@@ rtl/core/rgb_led_chain_serializer.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: cmd, pixel, red, green, blue (one waveform tick)
// m_*       out  m_tvalid/m_tready  m_tdata: line_level, busy_res, rejected; m_tlast: frame_done
// cfg_*     in   cfg_we             cfg_addr selects register, cfg_wdata is the value
//
// One item per clock, back to back, while s_tready is high; every item gives exactly
// one result item. The pixel RAM is read one byte ahead of the serializer, so its
// registered read never stalls the waveform; a set-pixel write lands via a write register.
// Reset (rst_n, async, active low) clears control and per-LED valid flags; an LED
// row that was never written reads as zero, so there is no clearing pass.
// A two-entry output buffer keeps s_tready high while one result waits on m_tready.
module rgb_led_chain_serializer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [1:0] cmd, [5:2] pixel, [13:6] red, [21:14] green,
                                   // [29:22] blue, [31:30] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] line_level, [1] busy_res, [2] rejected, [7:3] zero
    output logic        m_tlast,   // frame_done
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import lcs_pkg::*;

    cfg_t             cfg_reg;
    item_t            item;
    res_t             res;
    set_req_t         set_req;
    logic [LED_W-1:0] rd_row;
    logic [ROW_W-1:0] cur_row;
    logic             sending;
    logic             step;
    logic             pop;

    // Output buffer: main entry drives the port, skid entry catches one more item
    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;

    assign item = item_t'(s_tdata[29:0]);

    // Configuration registers; an index is taken as it comes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness <= 8'd100;
            cfg_reg.bit_period <= 8'd20;
            cfg_reg.zero_high  <= 8'd5;
            cfg_reg.one_high   <= 8'd13;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BRIGHTNESS: cfg_reg.brightness <= cfg_wdata;
                REG_BIT_PERIOD: cfg_reg.bit_period <= cfg_wdata;
                REG_ZERO_HIGH:  cfg_reg.zero_high  <= cfg_wdata;
                REG_ONE_HIGH:   cfg_reg.one_high   <= cfg_wdata;
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign step     = s_tvalid && s_tready;
    assign pop      = main_valid_reg && m_tready;

    lcs_wave u_wave (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg_reg),
        .cur_row(cur_row),
        .res    (res),
        .set_req(set_req),
        .rd_row (rd_row),
        .sending(sending)
    );

    lcs_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .set_req   (set_req),
        .brightness(cfg_reg.brightness),
        .rd_row    (rd_row),
        .cur_row   (cur_row)
    );

    // Advance the output buffer: refill main from skid, park new items in skid when full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= step;
            end
            else
            begin
                main_valid_reg <= step;
            end
        end
        else if (step)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                if (step)
                begin
                    skid_reg <= res;
                end
            end
            else if (step)
            begin
                main_reg <= res;
            end
        end
        else if (step)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= res;
            end
            else
            begin
                main_reg <= res;
            end
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {5'd0, main_reg.rejected, main_reg.busy_res, main_reg.line_level};
    assign m_tlast  = main_reg.frame_done;

    // A pixel write never starts while a frame is on the line
    a_no_set_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        set_req.valid |-> !sending)
        else $error("set-pixel write issued during frame");

    // The skid entry is only ever occupied behind a full main entry
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with main entry empty");

    // A frame ends only on a busy tick, and the engine is idle right after it
    a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.frame_done) |-> (res.busy_res ##1 !sending))
        else $error("frame_done without frame ending");

    // Rejection is only reported for ticks that carry waveform
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.rejected) |-> (res.busy_res && sending))
        else $error("rejected flagged while idle");

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcs_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] CMD_IDLE  = 2'd0;
    localparam logic [1:0] CMD_SPARE = 2'd3;   // unused code, behaves as an idle tick

    localparam int STORE_BYTES    = 3 * NUM_LEDS;
    localparam int WATCHDOG_LIMIT = 3000;      // cycles with no item moving on either side
    localparam int HOLD_CYCLES    = 400;       // long receiver hold-off
    localparam int PHASE_ITEMS    = 40;        // least items per register setting
    localparam int REPORT_LIMIT   = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [1:0] cmd, [5:2] pixel, [13:6] red, [21:14] green,
                                   // [29:22] blue, [31:30] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [0] line_level, [1] busy_res, [2] rejected, [7:3] zero
    logic        m_tlast;          // frame_done
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [7:0]  cfg_wdata = '0;

    rgb_led_chain_serializer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // Serializer shadow: registers, pixel bytes and waveform position
    // ------------------------------------------------------------------
    cfg_t       regs;
    logic [7:0] led_bytes [STORE_BYTES];
    int         byte_pos;
    int         bit_pos;
    logic [7:0] tick_cnt;
    logic [7:0] shreg;
    logic       on_air;      // a frame is going out

    item_t tick_q [$];       // ticks waiting for the driver
    res_t  wave_q [$];       // line/status each accepted tick must produce
    int    n_queued  = 0;
    int    n_checked = 0;
    int    n_fail    = 0;

    // Advance the frame by one tick; return the line level and the end-of-frame flag.
    task automatic wave_tick(output logic line, output logic done);
        logic [7:0] high_ticks;
        high_ticks = shreg[7] ? regs.one_high : regs.zero_high;
        line = (tick_cnt < high_ticks);
        done = 1'b0;
        // bit_period of 0 or 1 still gives one tick per bit
        if (32'(tick_cnt) + 32'd1 >= 32'(regs.bit_period))
        begin
            tick_cnt = '0;
            shreg    = shreg << 1;
            bit_pos++;
            if (bit_pos == 8)
            begin
                bit_pos = 0;
                byte_pos++;
                if (byte_pos == STORE_BYTES)
                begin
                    byte_pos = 0;
                    shreg    = '0;
                    on_air   = 1'b0;
                    done     = 1'b1;
                end
                else
                begin
                    shreg = led_bytes[byte_pos];
                end
            end
        end
        else
        begin
            tick_cnt++;
        end
    endtask

    // Work out the result of one accepted tick and update the shadow.
    task automatic serializer_step(input item_t it, output res_t r);
        logic [15:0] prod_r;
        logic [15:0] prod_g;
        logic [15:0] prod_b;
        logic        ln;
        logic        dn;
        int          base;
        r = '0;
        if (on_air)
        begin
            // commands are dropped while a frame goes out; the spare code is not flagged
            r.rejected = (it.cmd == CMD_SET) || (it.cmd == CMD_START);
            r.busy_res = 1'b1;
            wave_tick(ln, dn);
            r.line_level = ln;
            r.frame_done = dn;
        end
        else if (it.cmd == CMD_SET)
        begin
            if (int'(it.pixel) < NUM_LEDS)
            begin
                prod_r = {8'd0, it.red}   * {8'd0, regs.brightness};
                prod_g = {8'd0, it.green} * {8'd0, regs.brightness};
                prod_b = {8'd0, it.blue}  * {8'd0, regs.brightness};
                base   = 3 * int'(it.pixel);
                // transmit order is green, red, blue
                led_bytes[base]     = prod_g[15:8];
                led_bytes[base + 1] = prod_r[15:8];
                led_bytes[base + 2] = prod_b[15:8];
            end
        end
        else if (it.cmd == CMD_START)
        begin
            // the start tick is already tick 0 of the first bit
            on_air   = 1'b1;
            byte_pos = 0;
            bit_pos  = 0;
            tick_cnt = '0;
            shreg    = led_bytes[0];
            r.busy_res = 1'b1;
            wave_tick(ln, dn);
            r.line_level = ln;
            r.frame_done = dn;
        end
    endtask

    // Ticks still needed to finish the frame in progress.
    function automatic int ticks_left();
        int per;
        per = (regs.bit_period < 8'd2) ? 1 : int'(regs.bit_period);
        return ((STORE_BYTES - byte_pos) * 8 - bit_pos) * per - int'(tick_cnt);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Anything may arrive mid-frame; outside a frame hold back the start code.
    function automatic logic [1:0] pick_noise_cmd(input bit allow_start);
        case ($urandom_range(0, 9))
            0:       return CMD_SET;
            1:       return allow_start ? CMD_START : CMD_SET;
            2:       return CMD_SPARE;
            default: return CMD_IDLE;
        endcase
    endfunction

    function automatic item_t make_item(input logic [1:0] c, input logic [3:0] px,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        item_t it;
        it.cmd   = c;
        it.pixel = px;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        return it;
    endfunction

    function automatic item_t rand_item(input logic [1:0] c);
        return make_item(c, 4'($urandom), pick_level(), pick_level(), pick_level());
    endfunction

    task automatic queue_tick(input item_t it);
        tick_q.push_back(it);
        n_queued++;
    endtask

    // Wait until every queued tick has come back as a checked result.
    task automatic drain();
        do
            @(posedge clk);
        while (n_checked < n_queued);
        repeat (4) @(posedge clk);
    endtask

    // Feed noise until the frame in progress ends; optionally start the next
    // frame on the tick right after the last one.
    task automatic run_out_frame(input bit restart);
        bit again;
        int n;
        again = restart;
        drain();
        while (on_air)
        begin
            n = ticks_left();
            repeat (n) queue_tick(rand_item(pick_noise_cmd(1'b1)));
            if (again)
                queue_tick(rand_item(CMD_START));
            again = 1'b0;
            drain();
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_BRIGHTNESS: regs.brightness = val;
            REG_BIT_PERIOD: regs.bit_period = val;
            REG_ZERO_HIGH:  regs.zero_high  = val;
            REG_ONE_HIGH:   regs.one_high   = val;
            default:        ;
        endcase
    endtask

    task automatic apply_regs(input logic [7:0] b, input logic [7:0] p,
                              input logic [7:0] z, input logic [7:0] o);
        write_reg(REG_BRIGHTNESS, b);
        write_reg(REG_BIT_PERIOD, p);
        write_reg(REG_ZERO_HIGH,  z);
        write_reg(REG_ONE_HIGH,   o);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of back-to-back ticks separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !s_tready)
        begin
            // hold the offered item until it is taken
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            s_tvalid <= 1'b0;
        end
        else if (tick_q.size() > 0)
        begin
            nxt = tick_q.pop_front();
            s_tdata  <= {2'b00, nxt};
            s_tvalid <= 1'b1;
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                // long gapless stretches now and then, short choppy bursts otherwise
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 500)
                                                         : $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern cycling through four modes, plus one long hold-off
    // ------------------------------------------------------------------
    int rx_cyc    = 0;
    int hold_left = 0;
    bit held      = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            rx_cyc++;
            // stop draining for a long stretch while a frame is queued, so the
            // output buffer fills and the block has to push back on its input
            if (!held && tick_q.size() > 200)
            begin
                hold_left = HOLD_CYCLES;
                held      = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case ((rx_cyc / 128) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 2) == 0);
                    default: m_tready <= (rx_cyc % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted input item, check each accepted result.
    // Both sides are sampled from pre-edge values, so the order against the
    // driver does not matter.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        item_t it;
        res_t  want;
        res_t  got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                it = s_tdata[29:0];
                serializer_step(it, want);
                wave_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.line_level = m_tdata[0];
                got.busy_res   = m_tdata[1];
                got.frame_done = m_tlast;
                got.rejected   = m_tdata[2];
                if (wave_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing expected", n_checked);
                end
                else
                begin
                    want = wave_q.pop_front();
                    if (got !== want)
                    begin
                        n_fail++;
                        if (n_fail <= REPORT_LIMIT)
                            $display({"result %0d mismatch: expected line %0b busy %0b ",
                                      "done %0b rejected %0b, got line %b busy %b ",
                                      "done %b rejected %b"},
                                     n_checked, want.line_level, want.busy_res,
                                     want.frame_done, want.rejected, got.line_level,
                                     got.busy_res, got.frame_done, got.rejected);
                    end
                end
                n_checked++;
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    int quiet = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT)
                begin
                    $display("rgb_led_chain_serializer regression: fail");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int         n0;
        logic [7:0] b;
        logic [7:0] p;
        logic [7:0] z;
        logic [7:0] o;

        // reset values of the registers and a cleared pixel store
        regs.brightness = 8'd100;
        regs.bit_period = 8'd20;
        regs.zero_high  = 8'd5;
        regs.one_high   = 8'd13;
        foreach (led_bytes[i])
            led_bytes[i] = '0;
        byte_pos = 0;
        bit_pos  = 0;
        tick_cnt = '0;
        shreg    = '0;
        on_air   = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, pixels scaled at the reset brightness.
        // Idle and spare codes with every field bit set: no effect.
        queue_tick(make_item(CMD_IDLE,  4'hF, 8'hFF, 8'hFF, 8'hFF));
        queue_tick(make_item(CMD_SPARE, 4'hF, 8'hFF, 8'hFF, 8'hFF));
        // Extremes of LED index and colour, mostly one colour at a time.
        queue_tick(make_item(CMD_SET, 4'd0,  8'hFF, 8'hFF, 8'hFF));
        queue_tick(make_item(CMD_SET, 4'd15, 8'hFF, 8'h00, 8'h00));
        queue_tick(make_item(CMD_SET, 4'd7,  8'h00, 8'hFF, 8'h00));
        queue_tick(make_item(CMD_SET, 4'd8,  8'h00, 8'h00, 8'hFF));
        queue_tick(make_item(CMD_SET, 4'd1,  8'h00, 8'h00, 8'h00));
        queue_tick(make_item(CMD_SET, 4'd2,  8'h01, 8'h80, 8'hFE));
        drain();

        // One tick per bit with the line following each data bit.
        write_reg(REG_BIT_PERIOD, 8'd1);
        write_reg(REG_ZERO_HIGH,  8'd0);
        write_reg(REG_ONE_HIGH,   8'd1);
        queue_tick(make_item(CMD_START, 4'd0, 8'h00, 8'h00, 8'h00));
        // While busy: set and start are dropped and flagged, spare is not flagged.
        queue_tick(make_item(CMD_SET,   4'd3, 8'hFF, 8'hFF, 8'hFF));
        queue_tick(make_item(CMD_START, 4'd0, 8'h00, 8'h00, 8'h00));
        queue_tick(make_item(CMD_SPARE, 4'd0, 8'h00, 8'h00, 8'h00));
        queue_tick(make_item(CMD_IDLE,  4'd0, 8'h00, 8'h00, 8'h00));
        // Finish the frame and start the next one on the very next tick.
        run_out_frame(1'b1);

        // Random part: one register setting per phase.
        for (int ph = 0; ph < 2; ph++)
        begin
            case (ph)
                0:
                begin
                    // zero bit period, line inverted against the data
                    b = 8'd255; p = 8'd0; z = 8'd1; o = 8'd0;
                end
                default:
                begin
                    // two ticks per bit; a one stays high past the period
                    b = 8'($urandom); p = 8'd2; z = 8'd1; o = 8'd254;
                end
            endcase
            apply_regs(b, p, z, o);

            n0 = n_queued;
            while (n_queued - n0 < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // well-formed: load some LEDs, send, poke the block while busy
                    repeat ($urandom_range(1, 8))
                    begin
                        queue_tick(rand_item(CMD_SET));
                        if ($urandom_range(0, 3) == 0)
                            queue_tick(rand_item(pick_noise_cmd(1'b0)));
                    end
                    queue_tick(rand_item(CMD_START));
                    repeat ($urandom_range(0, 30))
                        queue_tick(rand_item(pick_noise_cmd(1'b1)));
                    run_out_frame(1'b0);
                end
                else
                begin
                    // noise: stray sets and idle ticks with no frame behind them
                    repeat ($urandom_range(1, 20))
                        queue_tick(rand_item(pick_noise_cmd(1'b0)));
                end
            end
            run_out_frame(1'b0);
        end

        drain();
        repeat (16) @(posedge clk);
        n_fail += wave_q.size();
        if (n_fail == 0)
            $display("rgb_led_chain_serializer regression: pass");
        else
            $display("rgb_led_chain_serializer regression: fail");
        $finish;
    end

endmodule
